[design/slpg_pkg.sv]
// Shared types, codes and constants of the status LED pattern generator.
package slpg_pkg;

  typedef enum logic [2:0] {
    MODE_OFF       = 3'd0,
    MODE_IDLE      = 3'd1,
    MODE_SCANNING  = 3'd2,
    MODE_CONNECTED = 3'd3,
    MODE_ERROR     = 3'd4,
    MODE_CUSTOM    = 3'd5
  } mode_t;

  typedef enum logic [2:0] {
    CFG_MODE         = 3'd0,
    CFG_CUSTOM_RED   = 3'd1,
    CFG_CUSTOM_GREEN = 3'd2,
    CFG_CUSTOM_BLUE  = 3'd3,
    CFG_CUSTOM_VALID = 3'd4
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_READY,
    ST_DIM,
    ST_DIV,
    ST_DONE
  } ctl_state_t;

  // Color word: [2] red, [1] green, [0] blue.
  typedef logic [2:0][7:0] rgb_t;

  localparam int NUM_CH = 3;

  localparam rgb_t PALETTE [4] = '{
    {8'd255, 8'd30,  8'd0},
    {8'd0,   8'd220, 8'd60},
    {8'd0,   8'd220, 8'd255},
    {8'd180, 8'd0,   8'd255}
  };

  localparam rgb_t COLOR_BLACK     = {8'd0,   8'd0,   8'd0};
  localparam rgb_t COLOR_CONNECTED = {8'd0,   8'd255, 8'd60};
  localparam rgb_t COLOR_ERROR     = {8'd255, 8'd0,   8'd0};

  localparam logic [7:0] DIM_OFFSET = 8'd30;
  localparam logic [8:0] BLEND_STEP = 9'd4;
  localparam logic [8:0] RAMP_STEP  = 9'd15;
  localparam logic [7:0] RAMP_LOW   = 8'd10;
  localparam logic [7:0] RAMP_HIGH  = 8'd255;
  localparam logic [7:0] RAMP_TURN  = 8'd25;

  // Division by 158 is a halving followed by a reciprocal multiply for 79.
  localparam int          DIV_SHIFT = 21;
  localparam logic [14:0] DIV_RECIP = 15'd26547;

  typedef struct packed {
    logic accept;
    logic dim_en;
    logic div_en;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic produce;
    logic multi;
  } status_t;

endpackage

[design/slpg_ctrl.sv]
// Controller state machine: handshakes and sequencing of the datapath.
module slpg_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              out_ready,
  output logic              out_valid,
  input  slpg_pkg::status_t status,
  output slpg_pkg::cmd_t    cmd
);
  import slpg_pkg::*;

  ctl_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_READY;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_READY: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          // A transaction with no result leaves the controller ready.
          if (status.produce) begin
            state_nxt = status.multi ? ST_DIM : ST_DONE;
          end
        end
      end
      ST_DIM: begin
        cmd.dim_en = 1'b1;
        state_nxt  = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_en = 1'b1;
        state_nxt  = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_READY;
        end
      end
      default: state_nxt = ST_READY;
    endcase
  end

  always_comb begin
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_valid = out_valid_r;

  a_idle_seq: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_READY && in_valid && status.produce && status.multi)
      |=> state_r == ST_DIM ##1 state_r == ST_DIV ##1 state_r == ST_DONE)
    else $error("idle-mode item did not run the dim and divide steps");

  a_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_READY && in_valid && !status.produce) |=> state_r == ST_READY)
    else $error("transaction without a result left the ready state");

  a_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && out_valid_r && !out_ready) |=> state_r == ST_DONE)
    else $error("result overwrote an output still waiting");

  a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |=> out_valid_r)
    else $error("loaded result not presented");

endmodule

[design/slpg_dp.sv]
// Datapath: configuration registers, animation state, blend and dim arithmetic.
module slpg_dp (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_hold,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [7:0]        cfg_wdata,
  input  slpg_pkg::cmd_t    cmd,
  output slpg_pkg::status_t status,
  output logic [7:0]        out_red,
  output logic [7:0]        out_green,
  output logic [7:0]        out_blue
);
  import slpg_pkg::*;

  // Configuration registers.
  logic [2:0] mode_r;
  rgb_t       cust_r;
  logic       cust_valid_r;

  // Animation state.
  logic [7:0] ramp_step_r, ramp_step_nxt;
  logic       ramp_rising_r, ramp_rising_nxt;
  logic [7:0] blend_phase_r, blend_phase_nxt;
  logic [1:0] pal_idx_r, pal_idx_nxt;

  // Arithmetic pipeline and output registers.
  rgb_t        v_r, v_nxt;
  logic [7:0]  sc_r, sc_nxt;
  logic [15:0] prod_r [NUM_CH];
  rgb_t        res_r, res_nxt;
  rgb_t        quot;
  rgb_t        out_r;

  logic        produce;
  logic        upd;
  logic [8:0]  rise_sum;
  logic [7:0]  scan_step;
  logic        scan_rising;
  logic [1:0]  pal_next;
  rgb_t        c1, c2;
  logic [7:0]  scale;
  logic [8:0]  phase_sum;
  logic signed [9:0]  diff  [NUM_CH];
  logic signed [18:0] bprod [NUM_CH];
  logic signed [18:0] bsum  [NUM_CH];
  logic [29:0] qprod [NUM_CH];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= MODE_IDLE;
      cust_r       <= COLOR_BLACK;
      cust_valid_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MODE:         mode_r       <= cfg_wdata[2:0];
        CFG_CUSTOM_RED:   cust_r[2]    <= cfg_wdata;
        CFG_CUSTOM_GREEN: cust_r[1]    <= cfg_wdata;
        CFG_CUSTOM_BLUE:  cust_r[0]    <= cfg_wdata;
        CFG_CUSTOM_VALID: cust_valid_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (mode_r) inside
      MODE_OFF, MODE_IDLE, MODE_SCANNING, MODE_CONNECTED, MODE_ERROR: produce = 1'b1;
      MODE_CUSTOM: produce = cust_valid_r;
      default:     produce = 1'b0;
    endcase
    produce = produce & ~in_hold;
  end

  assign status = '{produce: produce, multi: (mode_r == MODE_IDLE)};
  assign upd    = cmd.accept & produce;

  // Scanning ramp: clamped triangle between the low and high levels.
  always_comb begin
    rise_sum    = {1'b0, ramp_step_r} + RAMP_STEP;
    scan_step   = ramp_step_r;
    scan_rising = ramp_rising_r;
    if (ramp_rising_r) begin
      if (rise_sum >= {1'b0, RAMP_HIGH}) begin
        scan_step   = RAMP_HIGH;
        scan_rising = 1'b0;
      end else begin
        scan_step = rise_sum[7:0];
      end
    end else begin
      if (ramp_step_r <= RAMP_TURN) begin
        scan_step   = RAMP_LOW;
        scan_rising = 1'b1;
      end else begin
        scan_step = ramp_step_r - RAMP_STEP[7:0];
      end
    end
  end

  // Idle crossfade: blend written as c1*256 + (c2-c1)*t, one multiply per channel.
  always_comb begin
    pal_next  = pal_idx_r + 2'd1;
    c1        = PALETTE[pal_idx_r];
    c2        = PALETTE[pal_next];
    scale     = (blend_phase_r <= 8'd128) ? blend_phase_r
                                          : 8'(9'd256 - {1'b0, blend_phase_r});
    sc_nxt    = scale + DIM_OFFSET;
    phase_sum = {1'b0, blend_phase_r} + BLEND_STEP;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      diff[ch]  = $signed({2'b00, c2[ch]}) - $signed({2'b00, c1[ch]});
      bprod[ch] = 19'(diff[ch] * $signed({1'b0, blend_phase_r}));
      bsum[ch]  = $signed({3'b000, c1[ch], 8'd0}) + bprod[ch];
      v_nxt[ch] = bsum[ch][15:8];
      qprod[ch] = 30'(prod_r[ch][15:1]) * 30'(DIV_RECIP);
      quot[ch]  = qprod[ch][DIV_SHIFT+7:DIV_SHIFT];
    end
  end

  always_comb begin
    ramp_step_nxt   = ramp_step_r;
    ramp_rising_nxt = ramp_rising_r;
    blend_phase_nxt = blend_phase_r;
    pal_idx_nxt     = pal_idx_r;
    res_nxt         = COLOR_BLACK;
    case (mode_r)
      MODE_IDLE: begin
        if (phase_sum[8]) begin
          blend_phase_nxt = 8'd0;
          pal_idx_nxt     = pal_next;
        end else begin
          blend_phase_nxt = phase_sum[7:0];
        end
      end
      MODE_SCANNING: begin
        ramp_step_nxt   = scan_step;
        ramp_rising_nxt = scan_rising;
        res_nxt         = {8'd0, scan_step, 8'd255 - {1'b0, scan_step[7:1]}};
      end
      MODE_CONNECTED: res_nxt = COLOR_CONNECTED;
      MODE_ERROR: begin
        ramp_step_nxt = {7'd0, ~ramp_step_r[0]};
        res_nxt       = ramp_step_r[0] ? COLOR_BLACK : COLOR_ERROR;
      end
      MODE_CUSTOM: res_nxt = cust_r;
      default:     res_nxt = COLOR_BLACK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ramp_step_r   <= 8'd0;
      ramp_rising_r <= 1'b1;
      blend_phase_r <= 8'd0;
      pal_idx_r     <= 2'd0;
    end else if (upd) begin
      ramp_step_r   <= ramp_step_nxt;
      ramp_rising_r <= ramp_rising_nxt;
      blend_phase_r <= blend_phase_nxt;
      pal_idx_r     <= pal_idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      v_r   <= v_nxt;
      sc_r  <= sc_nxt;
      res_r <= res_nxt;
    end
    if (cmd.dim_en) begin
      for (int ch = 0; ch < NUM_CH; ch++) begin
        prod_r[ch] <= 16'(v_r[ch]) * 16'(sc_r);
      end
    end
    if (cmd.div_en) begin
      res_r <= quot;
    end
    if (cmd.load_out) begin
      out_r <= res_r;
    end
  end

  assign out_red   = out_r[2];
  assign out_green = out_r[1];
  assign out_blue  = out_r[0];

endmodule

[design/status_led_pattern_generator_unit.sv]
// Off, scanning, connected, error and custom results go straight to the done state.
// Idle results pass through blend, dim multiply and reciprocal multiply first.
// A held tick or one without a result leaves the input ready.
// A new transaction is accepted only once the last result is loaded for output.
// The output register lets the next transaction be accepted while a result waits.
// Synchronous active-low reset: mode idle, custom color cleared, ramp rising at 0.
module status_led_pattern_generator_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_hold,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_red,
  output logic [7:0] out_green,
  output logic [7:0] out_blue,
  input  logic       cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [7:0] cfg_wdata
);
  import slpg_pkg::*;

  cmd_t    cmd;
  status_t status;

  slpg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .status    (status),
    .cmd       (cmd)
  );

  slpg_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_hold   (in_hold),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .status    (status),
    .out_red   (out_red),
    .out_green (out_green),
    .out_blue  (out_blue)
  );

endmodule

[dv/status_led_pattern_generator_unit_tb.sv]
// Self-checking testbench for the status LED pattern generator with a built-in color predictor.
`timescale 1ns / 100ps

module status_led_pattern_generator_unit_tb;
  import slpg_pkg::*;

  localparam int          CLK_HALF     = 10;
  localparam int          RESET_CYCLES = 7;
  localparam int          SETTLE       = 8;
  localparam int          DRAIN_LIMIT  = 20000;
  localparam int          RAND_TICKS   = 900;
  localparam int unsigned DIM_DIV      = 158;
  localparam logic [2:0]  MODE_RSVD6   = 3'd6;
  localparam logic [2:0]  MODE_RSVD7   = 3'd7;
  localparam logic [2:0]  CFG_RSVD5    = 3'd5;
  localparam logic [2:0]  CFG_RSVD6    = 3'd6;
  localparam logic [2:0]  CFG_RSVD7    = 3'd7;

  typedef enum logic [1:0] {
    EXP_MODEL,
    EXP_NONE,
    EXP_RGB
  } exp_kind_t;

  typedef struct packed {
    logic       is_cfg;
    logic [2:0] idx;
    logic [7:0] data;
    logic       hold;
    exp_kind_t  kind;
    rgb_t       rgb;
  } stim_row_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic       in_hold = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  logic       cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [7:0] cfg_wdata = '0;

  // Shadow copy of the configuration and the animation state.
  logic [2:0] sh_mode = MODE_IDLE;
  logic [7:0] sh_red = '0;
  logic [7:0] sh_green = '0;
  logic [7:0] sh_blue = '0;
  logic       sh_valid = 1'b0;
  logic [7:0] ramp_lvl = '0;
  logic       ramp_up = 1'b1;
  logic [7:0] blend_t = '0;
  logic [1:0] pal_idx = '0;

  rgb_t      pending_colors[$];
  stim_row_t table_rows[$];
  int        err_count = 0;
  int        colors_checked = 0;
  int        tick_count = 0;
  int        phase_count = 0;
  int        burst_left = 0;

  status_led_pattern_generator_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_hold   (in_hold),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_red   (out_red),
    .out_green (out_green),
    .out_blue  (out_blue),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // Advances the shadow state by one tick and returns whether a color comes out.
  function automatic logic led_color_next(input logic hold, output rgb_t color);
    int unsigned t;
    int unsigned s;
    int unsigned st;
    int unsigned v;
    logic [1:0]  nxt;
    int          ch;
    color = COLOR_BLACK;
    if (hold) return 1'b0;
    case (sh_mode)
      MODE_OFF: return 1'b1;
      MODE_IDLE: begin
        nxt = pal_idx + 2'd1;
        t = blend_t;
        s = (t <= 128) ? t : 256 - t;
        for (ch = 0; ch < NUM_CH; ch++) begin
          v = (PALETTE[pal_idx][ch] * (256 - t) + PALETTE[nxt][ch] * t) >> 8;
          color[ch] = 8'((v * (s + DIM_OFFSET)) / DIM_DIV);
        end
        t = t + BLEND_STEP;
        if (t >= 256) begin
          t = 0;
          pal_idx = nxt;
        end
        blend_t = 8'(t);
        return 1'b1;
      end
      MODE_SCANNING: begin
        st = ramp_lvl;
        if (ramp_up) begin
          st = st + RAMP_STEP;
          if (st >= RAMP_HIGH) begin
            st = RAMP_HIGH;
            ramp_up = 1'b0;
          end
        end else if (st <= RAMP_LOW + RAMP_STEP) begin
          st = RAMP_LOW;
          ramp_up = 1'b1;
        end else begin
          st = st - RAMP_STEP;
        end
        ramp_lvl = 8'(st);
        color = {8'd0, 8'(st), 8'(255 - st / 2)};
        return 1'b1;
      end
      MODE_CONNECTED: begin
        color = COLOR_CONNECTED;
        return 1'b1;
      end
      MODE_ERROR: begin
        // The blink shares the ramp register and keeps only its low bit.
        ramp_lvl = {7'd0, ~ramp_lvl[0]};
        color = ramp_lvl[0] ? COLOR_ERROR : COLOR_BLACK;
        return 1'b1;
      end
      MODE_CUSTOM: begin
        if (!sh_valid) return 1'b0;
        color = {sh_red, sh_green, sh_blue};
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic [7:0] rand_byte();
    if ($urandom_range(0, 3) == 0) return $urandom_range(0, 1) ? 8'hFF : 8'h00;
    return 8'($urandom_range(0, 255));
  endfunction

  // Called at a falling edge with the input channel idle; returns at a falling edge.
  task automatic write_reg(input logic [2:0] idx, input logic [7:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    case (idx)
      CFG_MODE:         sh_mode  = data[2:0];
      CFG_CUSTOM_RED:   sh_red   = data;
      CFG_CUSTOM_GREEN: sh_green = data;
      CFG_CUSTOM_BLUE:  sh_blue  = data;
      CFG_CUSTOM_VALID: sh_valid = data[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic send_tick(input logic hold, input exp_kind_t kind, input rgb_t lit,
                           output logic produced);
    rgb_t color;
    in_valid <= 1'b1;
    in_hold  <= hold;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    produced = led_color_next(hold, color);
    tick_count++;
    if (kind == EXP_RGB) pending_colors.push_back(lit);
    else if (kind == EXP_MODEL && produced) pending_colors.push_back(color);
    @(negedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                : $urandom_range(1, 10);
    end
  endtask

  // Config writes happen only after every result is back and any silent tick has drained.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_colors.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic add_cfg(input logic [2:0] idx, input logic [7:0] data);
    table_rows.push_back('{1'b1, idx, data, 1'b0, EXP_NONE, COLOR_BLACK});
  endtask

  task automatic add_tick(input logic hold, input exp_kind_t kind, input rgb_t rgb);
    table_rows.push_back('{1'b0, 3'd0, 8'd0, hold, kind, rgb});
  endtask

  // The receiver switches between stall behaviors: always ready, random, a rotating pattern, or mostly ready.
  int         rx_cycle = 0;
  int         rx_style = 0;
  logic [7:0] rx_pattern = 8'hFF;
  always @(negedge clk) begin
    if (rx_cycle % 50 == 0) begin
      rx_style   = $urandom_range(0, 3);
      rx_pattern = 8'($urandom_range(1, 255));
    end
    rx_cycle++;
    rx_pattern = {rx_pattern[6:0], rx_pattern[7]};
    case (rx_style)
      0:       out_ready <= 1'b1;
      1:       out_ready <= 1'($urandom_range(0, 1));
      2:       out_ready <= rx_pattern[0];
      default: out_ready <= ($urandom_range(0, 3) != 0);
    endcase
  end

  always @(posedge clk) begin
    rgb_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_colors.size() == 0) begin
        $error("unexpected color: red %0d green %0d blue %0d", out_red, out_green, out_blue);
        err_count++;
      end else begin
        want = pending_colors.pop_front();
        colors_checked++;
        if (out_red !== want[2]) begin
          $error("red: expected %0d, actual %0d", want[2], out_red);
          err_count++;
        end
        if (out_green !== want[1]) begin
          $error("green: expected %0d, actual %0d", want[1], out_green);
          err_count++;
        end
        if (out_blue !== want[0]) begin
          $error("blue: expected %0d, actual %0d", want[0], out_blue);
          err_count++;
        end
      end
    end
  end

  initial begin
    #10ms;
    $error("run did not finish in time");
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    stim_row_t  row;
    logic       got;
    logic [2:0] mode_pick;
    int         produced_total;
    int         n;
    int         r;
    int         drained;

    // Directed sequence: reset state, every mode, holds, and the ignored cases.
    add_tick(1'b0, EXP_RGB, {8'd48, 8'd5, 8'd0});
    add_tick(1'b1, EXP_NONE, COLOR_BLACK);
    add_tick(1'b0, EXP_MODEL, COLOR_BLACK);
    add_cfg(CFG_MODE, MODE_CUSTOM);
    add_tick(1'b0, EXP_NONE, COLOR_BLACK);
    add_cfg(CFG_CUSTOM_RED, 8'hFF);
    add_cfg(CFG_CUSTOM_GREEN, 8'h00);
    add_cfg(CFG_CUSTOM_BLUE, 8'hFF);
    add_cfg(CFG_CUSTOM_VALID, 8'h01);
    add_tick(1'b0, EXP_RGB, {8'd255, 8'd0, 8'd255});
    add_cfg(CFG_CUSTOM_RED, 8'h00);
    add_cfg(CFG_CUSTOM_GREEN, 8'hFF);
    add_cfg(CFG_CUSTOM_BLUE, 8'h00);
    add_tick(1'b0, EXP_RGB, {8'd0, 8'd255, 8'd0});
    add_cfg(CFG_CUSTOM_VALID, 8'h00);
    add_tick(1'b0, EXP_NONE, COLOR_BLACK);
    add_cfg(CFG_MODE, MODE_OFF);
    add_tick(1'b0, EXP_RGB, COLOR_BLACK);
    add_cfg(CFG_MODE, MODE_CONNECTED);
    add_tick(1'b0, EXP_RGB, COLOR_CONNECTED);
    add_tick(1'b1, EXP_NONE, COLOR_BLACK);
    add_cfg(CFG_MODE, MODE_ERROR);
    add_tick(1'b0, EXP_RGB, COLOR_ERROR);
    add_tick(1'b0, EXP_RGB, COLOR_BLACK);
    add_cfg(CFG_MODE, MODE_SCANNING);
    add_tick(1'b0, EXP_MODEL, COLOR_BLACK);
    add_tick(1'b1, EXP_NONE, COLOR_BLACK);
    add_tick(1'b0, EXP_MODEL, COLOR_BLACK);
    add_tick(1'b0, EXP_MODEL, COLOR_BLACK);
    add_cfg(CFG_MODE, MODE_RSVD6);
    add_tick(1'b0, EXP_NONE, COLOR_BLACK);
    add_cfg(CFG_MODE, MODE_RSVD7);
    add_tick(1'b0, EXP_NONE, COLOR_BLACK);
    add_cfg(CFG_RSVD5, 8'hFF);
    add_cfg(CFG_RSVD6, 8'hFF);
    add_cfg(CFG_RSVD7, 8'hFF);
    // Only the low three bits of the data select the mode.
    add_cfg(CFG_MODE, 8'hFB);
    add_tick(1'b0, EXP_RGB, COLOR_CONNECTED);

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (table_rows[i]) begin
      row = table_rows[i];
      if (row.is_cfg) begin
        wait_idle();
        write_reg(row.idx, row.data);
      end else begin
        send_tick(row.hold, row.kind, row.rgb, got);
      end
    end

    produced_total = 0;
    while (tick_count < RAND_TICKS) begin
      wait_idle();
      phase_count++;
      r = $urandom_range(0, 19);
      if (r < 6)       mode_pick = MODE_IDLE;
      else if (r < 11) mode_pick = MODE_SCANNING;
      else if (r < 14) mode_pick = MODE_ERROR;
      else if (r < 17) mode_pick = MODE_CUSTOM;
      else if (r == 17) mode_pick = MODE_OFF;
      else if (r == 18) mode_pick = MODE_CONNECTED;
      else mode_pick = $urandom_range(0, 1) ? MODE_RSVD6 : MODE_RSVD7;
      write_reg(CFG_MODE, {5'($urandom_range(0, 31)), mode_pick});
      if (mode_pick == MODE_CUSTOM || $urandom_range(0, 3) == 0) begin
        write_reg(CFG_CUSTOM_RED, rand_byte());
        write_reg(CFG_CUSTOM_GREEN, rand_byte());
        write_reg(CFG_CUSTOM_BLUE, rand_byte());
        write_reg(CFG_CUSTOM_VALID, ($urandom_range(0, 3) != 0) ? {7'($urandom), 1'b1}
                                                                  : {7'($urandom), 1'b0});
      end
      if ($urandom_range(0, 7) == 0)
        write_reg(3'($urandom_range(CFG_RSVD5, CFG_RSVD7)), 8'($urandom));
      // Long idle phases walk the whole palette; long scans hit both clamps.
      if (mode_pick == MODE_RSVD6 || mode_pick == MODE_RSVD7) n = $urandom_range(2, 6);
      else if ($urandom_range(0, 5) == 0) n = $urandom_range(60, 270);
      else n = $urandom_range(5, 40);
      repeat (n) begin
        send_tick(($urandom_range(0, 7) == 0), EXP_MODEL, COLOR_BLACK, got);
        if (got) produced_total++;
      end
    end

    in_valid <= 1'b0;
    drained = 0;
    while (pending_colors.size() != 0 && drained < DRAIN_LIMIT) begin
      @(negedge clk);
      drained++;
    end
    repeat (SETTLE) @(negedge clk);
    if (pending_colors.size() != 0) begin
      $error("%0d expected colors never arrived", pending_colors.size());
      err_count += pending_colors.size();
    end

    $display("Sent %0d ticks over %0d random configuration phases plus the directed set.",
             tick_count, phase_count);
    $display("Random ticks with a color: %0d; compared %0d output colors against the predictor.",
             produced_total, colors_checked);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
